>>> src/brf_pkg.sv
// types and constants shared by the byte ring fifo
package brf_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    typedef enum logic [2:0] {
        KIND_PUSH  = 3'd0,
        KIND_POP   = 3'd1,
        KIND_PEEK  = 3'd2,
        KIND_SKIP  = 3'd3,
        KIND_CLEAR = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       data_in;
        logic [CNT_W-1:0] amount;
    } t_req;

    typedef struct packed {
        logic             status;
        logic [7:0]       data_out;
        logic [CNT_W-1:0] fill_level;
        logic             is_empty;
        logic             is_full;
    } t_result;

endpackage

>>> src/byte_ring_fifo_peek_skip.sv
// byte ring fifo with push, pop, peek, skip and clear requests
// result: the result strobe o_done comes in the cycle after a request is taken
// throughput: one request per cycle; busy stays low, the store has one write
//   port and one registered read port and no request reads the entry written
//   by the request before it in a way that can overlap
// reset: synchronous, pointers and fill count clear; store contents are undefined
module byte_ring_fifo_peek_skip (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  brf_pkg::t_req    i_req,
    output logic             o_done,
    output brf_pkg::t_result o_result
);
    import brf_pkg::*;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        r_rd_data;

    logic [ADDR_W-1:0] r_wp, n_wp;
    logic [ADDR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_done;
    logic              r_status, n_status;
    logic              r_use_rd, n_use_rd;

    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] peek_addr;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign peek_addr = ADDR_W'(r_rp + i_req.amount[ADDR_W-1:0]);

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_count  = r_count;
        n_status = 1'b0;
        n_use_rd = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_rp;
        unique case (t_kind'(i_req.kind))
            KIND_PUSH: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_status = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    n_wp    = ADDR_W'(r_wp + 1'b1);
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            KIND_POP: begin
                if (r_count == '0) begin
                    n_status = 1'b1;
                end else begin
                    rd_en    = 1'b1;
                    n_use_rd = 1'b1;
                    n_rp     = ADDR_W'(r_rp + 1'b1);
                    n_count  = CNT_W'(r_count - 1'b1);
                end
            end
            KIND_PEEK: begin
                if (i_req.amount >= r_count) begin
                    n_status = 1'b1;
                end else begin
                    rd_en    = 1'b1;
                    n_use_rd = 1'b1;
                    rd_addr  = peek_addr;
                end
            end
            KIND_SKIP: begin
                if (i_req.amount > r_count) begin
                    n_status = 1'b1;
                end else begin
                    n_rp    = peek_addr;
                    n_count = CNT_W'(r_count - i_req.amount);
                end
            end
            KIND_CLEAR: begin
                n_wp    = '0;
                n_rp    = '0;
                n_count = '0;
            end
            default: begin
                n_status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            mem[r_wp] <= i_req.data_in;
        end
        if (accept && rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_status <= 1'b0;
            r_use_rd <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_wp     <= n_wp;
                r_rp     <= n_rp;
                r_count  <= n_count;
                r_status <= n_status;
                r_use_rd <= n_use_rd;
            end
        end
    end

    always_comb begin
        o_done              = r_done;
        o_result.status     = r_status;
        o_result.data_out   = r_use_rd ? r_rd_data : 8'd0;
        o_result.fill_level = r_count;
        o_result.is_empty   = (r_count == '0);
        o_result.is_full    = (r_count == CNT_W'(DEPTH));
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("no result after request");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.kind == KIND_CLEAR |=> o_result.is_empty && !o_result.status)
        else $error("clear did not empty the fifo");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_status |=> r_count == $past(r_count) && r_rp == $past(r_rp)
            && r_wp == $past(r_wp))
        else $error("rejected request changed state");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status |-> o_result.data_out == 8'd0)
        else $error("rejected request returned data");
`endif

endmodule

>>> tb/byte_ring_fifo_peek_skip_test.sv
// self-checking testbench for the byte ring fifo with peek and skip requests
module byte_ring_fifo_peek_skip_test;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam int         STALL_LIMIT    = 2000;
    localparam int         RANDOM_ITEMS   = 500;
    localparam int         CALM_FROM      = 250;
    localparam int         CALM_TO        = 350;
    localparam logic [2:0] KIND_LAST_CODE = 3'd7;

    class ring_scoreboard;
        logic [7:0]  bytes [DEPTH];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        int unsigned fill;
        t_result     pending_q[$];
        int          errors;

        function void note_request(t_req r);
            t_result     e;
            int unsigned amt;
            e = '0;
            amt = 32'(r.amount);
            case (r.kind)
                KIND_PUSH: begin
                    if (fill >= DEPTH) begin
                        e.status = 1'b1;
                    end else begin
                        bytes[ADDR_W'(wr_ptr)] = r.data_in;
                        wr_ptr = (wr_ptr + 1) % DEPTH;
                        fill++;
                    end
                end
                KIND_POP: begin
                    if (fill == 0) begin
                        e.status = 1'b1;
                    end else begin
                        e.data_out = bytes[ADDR_W'(rd_ptr)];
                        rd_ptr = (rd_ptr + 1) % DEPTH;
                        fill--;
                    end
                end
                KIND_PEEK: begin
                    if (amt >= fill) e.status = 1'b1;
                    else e.data_out = bytes[ADDR_W'(rd_ptr + amt)];
                end
                KIND_SKIP: begin
                    if (amt > fill) begin
                        e.status = 1'b1;
                    end else begin
                        rd_ptr = (rd_ptr + amt) % DEPTH;
                        fill -= amt;
                    end
                end
                KIND_CLEAR: begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                    fill = 0;
                end
                default: e.status = 1'b1;
            endcase
            e.fill_level = CNT_W'(fill);
            e.is_empty = (fill == 0);
            e.is_full = (fill == DEPTH);
            pending_q.push_back(e);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned got);
            if (exp != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, expected none, actual %0h",
                         $time, got);
                return;
            end
            e = pending_q.pop_front();
            compare_field("status", 32'(e.status), 32'(got.status));
            compare_field("data_out", 32'(e.data_out), 32'(got.data_out));
            compare_field("fill_level", 32'(e.fill_level), 32'(got.fill_level));
            compare_field("is_empty", 32'(e.is_empty), 32'(got.is_empty));
            compare_field("is_full", 32'(e.is_full), 32'(got.is_full));
        endfunction
    endclass

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_req    i_req   = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    ring_scoreboard sb = new();
    int             sent;
    int             stall_cycles;
    int             stop_at;

    byte_ring_fifo_peek_skip u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) sb.check_result(o_result);
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_req make_req(logic [2:0] kind, logic [7:0] data,
                                      logic [CNT_W-1:0] amount);
        t_req r;
        r.kind = kind;
        r.data_in = data;
        r.amount = amount;
        return r;
    endfunction

    task automatic send(t_req r);
        if (!(sent >= CALM_FROM && sent < CALM_TO)) begin
            while ($urandom_range(0, 99) < 18) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
        sent++;
    endtask

    task automatic random_item();
        int               pick;
        logic [2:0]       kind;
        logic [CNT_W-1:0] amt;
        pick = $urandom_range(0, 99);
        amt = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        if (pick < 36) begin
            kind = KIND_PUSH;
        end else if (pick < 60) begin
            kind = KIND_POP;
        end else if (pick < 80) begin
            kind = KIND_PEEK;
            if ($urandom_range(0, 9) < 7) amt = CNT_W'($urandom_range(0, sb.fill));
        end else if (pick < 92) begin
            kind = KIND_SKIP;
            case ($urandom_range(0, 9))
                0: amt = CNT_W'(sb.fill);
                1: amt = CNT_W'(sb.fill + 1);
                2: ;
                default: amt = CNT_W'($urandom_range(0, sb.fill < 8 ? sb.fill : 8));
            endcase
        end else if (pick < 96) begin
            kind = KIND_CLEAR;
        end else begin
            kind = 3'($urandom_range(KIND_CLEAR + 1, KIND_LAST_CODE));
        end
        send(make_req(kind, 8'($urandom_range(0, 255)), amt));
    endtask

    task automatic fill_up();
        while (sb.fill < DEPTH && sent < stop_at) begin
            send(make_req(KIND_PUSH, 8'($urandom_range(0, 255)),
                          CNT_W'($urandom_range(0, (1 << CNT_W) - 1))));
        end
        if (sb.fill == DEPTH) begin
            send(make_req(KIND_PUSH, 8'($urandom_range(0, 255)), '0));
            send(make_req(KIND_PEEK, '0, CNT_W'(DEPTH - 1)));
            send(make_req(KIND_PEEK, '0, CNT_W'(DEPTH)));
            send(make_req(KIND_SKIP, '0, CNT_W'(DEPTH + 1)));
        end
    endtask

    task automatic drain();
        while (sb.fill != 0 && sent < stop_at) begin
            if ($urandom_range(0, 3) == 0) send(make_req(KIND_SKIP, 8'($urandom_range(0, 255)),
                                                         CNT_W'($urandom_range(0, sb.fill))));
            else send(make_req(KIND_POP, 8'($urandom_range(0, 255)), '0));
        end
        send(make_req(KIND_POP, '0, '0));
    endtask

    initial begin
        int phase;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty buffer corner cases
        send(make_req(KIND_POP, '0, '0));
        send(make_req(KIND_PEEK, '0, '0));
        send(make_req(KIND_SKIP, '0, '0));
        send(make_req(KIND_SKIP, '0, CNT_W'(1)));
        // small contents, peek bounds and skip bounds, then unknown kinds and clear
        send(make_req(KIND_PUSH, 8'h00, '0));
        send(make_req(KIND_PUSH, 8'hff, '0));
        send(make_req(KIND_PUSH, 8'ha5, '0));
        send(make_req(KIND_PEEK, '0, CNT_W'(0)));
        send(make_req(KIND_PEEK, '0, CNT_W'(2)));
        send(make_req(KIND_PEEK, '0, CNT_W'(3)));
        send(make_req(KIND_PEEK, '0, CNT_W'(DEPTH)));
        send(make_req(KIND_PEEK, '1, '1));
        send(make_req(KIND_SKIP, '0, CNT_W'(4)));
        send(make_req(KIND_SKIP, '0, CNT_W'(1)));
        send(make_req(KIND_POP, '0, '0));
        for (int k = KIND_CLEAR + 1; k <= KIND_LAST_CODE; k++) send(make_req(3'(k), '1, '1));
        send(make_req(KIND_CLEAR, '0, '0));
        send(make_req(KIND_POP, '0, '0));
        send(make_req(KIND_PUSH, 8'h5a, '1));
        send(make_req(KIND_SKIP, '0, CNT_W'(1)));

        stop_at = sent + RANDOM_ITEMS;
        phase = 0;
        while (sent < stop_at) begin
            if (phase == 1 || $urandom_range(0, 11) == 0) fill_up();
            else if ($urandom_range(0, 7) == 0) drain();
            else repeat (40) random_item();
            phase++;
        end
        start <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/brf_pkg.sv
src/byte_ring_fifo_peek_skip.sv
tb/byte_ring_fifo_peek_skip_test.sv
